// File: hdl/lrq_pkg.sv
// Shared types and constants for the linked run-queue manager.
`default_nettype none
package lrq_pkg;

   localparam int NODE_COUNT_DEF = 64;
   localparam int LIST_COUNT_DEF = 4;

   localparam int MODE_W   = 3;
   localparam int LIST_W   = 2;
   localparam int NODE_W   = 6;
   localparam int STATUS_W = 2;
   localparam int MOVED_W  = 6;
   localparam int SIZE_W   = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ_TAIL  = 3'd0,
      MODE_PUSH_HEAD = 3'd1,
      MODE_DEQ_HEAD  = 3'd2,
      MODE_REM_TAIL  = 3'd3,
      MODE_UNLINK    = 3'd4,
      MODE_XFER_HALF = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_MEMBER = 2'd2,
      ST_SAME   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_SRC,
      S_RD_DST,
      S_DECIDE,
      S_LINK,
      S_TAG,
      S_STEP,
      S_XSRC,
      S_XDST,
      S_FIN
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic cap_src;
      logic cap_dst;
      logic decide;
      logic link;
      logic tag;
      logic step;
      logic xsrc;
      logic xdst;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic err;
      logic ins;
      logic det;
      logic walk_last;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// File: hdl/lrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: hdl/lrq_ctrl.sv
// Sequencer for the queue manager: clear pass, operand reads, update steps, result hand-off.
`default_nettype none
module lrq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lrq_pkg::stat_type stat,
   output lrq_pkg::cmd_type       cmd
);
   lrq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrq_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lrq_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) state_in = lrq_pkg::S_IDLE;
         end
         lrq_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) state_in = lrq_pkg::S_RD_SRC;
         end
         lrq_pkg::S_RD_SRC: begin
            cmd.cap_src = 1'b1;
            state_in    = lrq_pkg::S_RD_DST;
         end
         lrq_pkg::S_RD_DST: begin
            cmd.cap_dst = 1'b1;
            state_in    = lrq_pkg::S_DECIDE;
         end
         lrq_pkg::S_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.err || stat.ins) state_in = lrq_pkg::S_FIN;
            else if (stat.det)        state_in = lrq_pkg::S_LINK;
            else                      state_in = lrq_pkg::S_TAG;
         end
         lrq_pkg::S_LINK: begin
            cmd.link = 1'b1;
            state_in = lrq_pkg::S_FIN;
         end
         lrq_pkg::S_TAG: begin
            cmd.tag  = 1'b1;
            state_in = lrq_pkg::S_STEP;
         end
         lrq_pkg::S_STEP: begin
            cmd.step = 1'b1;
            state_in = stat.walk_last ? lrq_pkg::S_XSRC : lrq_pkg::S_TAG;
         end
         lrq_pkg::S_XSRC: begin
            cmd.xsrc = 1'b1;
            state_in = lrq_pkg::S_XDST;
         end
         lrq_pkg::S_XDST: begin
            cmd.xdst = 1'b1;
            state_in = lrq_pkg::S_FIN;
         end
         lrq_pkg::S_FIN: begin
            cmd.finish = stat.out_free;
            if (stat.out_free) state_in = lrq_pkg::S_IDLE;
         end
         default: begin
            state_in = lrq_pkg::S_CLEAR;
         end
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/lrq_dpath.sv
// Datapath: link, membership and list-descriptor memories, operand registers, result register.
`default_nettype none
module lrq_dpath #(
   parameter int NODE_COUNT = lrq_pkg::NODE_COUNT_DEF,
   parameter int LIST_COUNT = lrq_pkg::LIST_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lrq_pkg::cmd_type              cmd,
   output lrq_pkg::stat_type                  stat,
   input  wire logic [lrq_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [lrq_pkg::LIST_W-1:0]    req_list_id,
   input  wire logic [lrq_pkg::LIST_W-1:0]    req_dest_list,
   input  wire logic [lrq_pkg::NODE_W-1:0]    req_node_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [lrq_pkg::NODE_W-1:0]    rsp_node_out,
   output logic      [lrq_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [lrq_pkg::MOVED_W-1:0]   rsp_moved_count,
   output logic      [lrq_pkg::SIZE_W-1:0]    rsp_size_after
);
   localparam int NW      = $clog2(NODE_COUNT);
   localparam int CW      = $clog2(NODE_COUNT + 1);
   localparam int TW      = $clog2(LIST_COUNT + 1);
   localparam int LW      = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
   localparam int DW      = 2 * NW + CW;
   localparam int CLR_MAX = (NODE_COUNT > LIST_COUNT) ? NODE_COUNT : LIST_COUNT;
   localparam int CLW     = $clog2(CLR_MAX);

   // operand registers
   logic [lrq_pkg::MODE_W-1:0] mode_ff;
   logic [lrq_pkg::LIST_W-1:0] l_ff, d_ff;
   logic [NW-1:0]              p_ff;
   logic                       p_ok_ff;
   logic [TW-1:0]              tag_ff;
   logic [NW-1:0]              sh_ff, st_ff, dh_ff, dt_ff;
   logic [CW-1:0]              sc_ff, dc_ff;
   logic [NW-1:0]              q_ff, n_ff, pn_ff;
   logic [CW-1:0]              k_ff, i_ff;
   logic [CLW-1:0]             clr_ff;

   // pending result
   logic [lrq_pkg::NODE_W-1:0]   res_node_ff;
   logic [lrq_pkg::STATUS_W-1:0] res_status_ff;
   logic [lrq_pkg::MOVED_W-1:0]  res_moved_ff;
   logic [lrq_pkg::SIZE_W-1:0]   res_size_ff;

   logic                         rsp_valid_ff;
   logic [lrq_pkg::NODE_W-1:0]   rsp_node_ff;
   logic [lrq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [lrq_pkg::MOVED_W-1:0]  rsp_moved_ff;
   logic [lrq_pkg::SIZE_W-1:0]   rsp_size_ff;

   // memory ports
   logic          nx_we, pv_we, tg_we, ls_we;
   logic [NW-1:0] nx_wa, pv_wa, tg_wa, nx_ra, pv_ra, tg_ra;
   logic [NW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
   logic [TW-1:0] tg_wd, tg_rd;
   logic [LW-1:0] ls_wa, ls_ra;
   logic [DW-1:0] ls_wd, ls_rd;

   // decode
   logic                         l_bad, d_bad, e_err, e_ins, e_det;
   logic [lrq_pkg::STATUS_W-1:0] e_code;
   logic [TW-1:0]                lp1, dp1;
   logic [NW-1:0]                q_sel;
   logic [CW-1:0]                k_calc;
   logic [NW-1:0]                ls_h;
   logic [NW-1:0]                ls_t;
   logic [CW-1:0]                ls_c;

   assign lp1   = TW'(32'(l_ff) + 1);
   assign dp1   = TW'(32'(d_ff) + 1);
   assign l_bad = 32'(l_ff) >= LIST_COUNT;
   assign d_bad = 32'(d_ff) >= LIST_COUNT;
   assign k_calc = ((sc_ff >> 1) == '0) ? CW'(1) : (sc_ff >> 1);

   always_comb begin
      case (mode_ff)
         lrq_pkg::MODE_DEQ_HEAD: q_sel = sh_ff;
         lrq_pkg::MODE_REM_TAIL: q_sel = st_ff;
         default:                q_sel = p_ff;
      endcase
   end

   always_comb begin
      e_err  = 1'b0;
      e_ins  = 1'b0;
      e_det  = 1'b0;
      e_code = lrq_pkg::ST_OK;
      if (l_bad || (mode_ff == lrq_pkg::MODE_XFER_HALF && d_bad)) begin
         e_err  = 1'b1;
         e_code = lrq_pkg::ST_MEMBER;
      end else begin
         case (mode_ff) inside
            lrq_pkg::MODE_ENQ_TAIL, lrq_pkg::MODE_PUSH_HEAD: begin
               if (!p_ok_ff || tag_ff != '0) begin
                  e_err  = 1'b1;
                  e_code = lrq_pkg::ST_MEMBER;
               end else begin
                  e_ins = 1'b1;
               end
            end
            lrq_pkg::MODE_DEQ_HEAD, lrq_pkg::MODE_REM_TAIL: begin
               if (sc_ff == '0) begin
                  e_err  = 1'b1;
                  e_code = lrq_pkg::ST_EMPTY;
               end else begin
                  e_det = 1'b1;
               end
            end
            lrq_pkg::MODE_UNLINK: begin
               if (!p_ok_ff || tag_ff != lp1) begin
                  e_err  = 1'b1;
                  e_code = lrq_pkg::ST_MEMBER;
               end else begin
                  e_det = 1'b1;
               end
            end
            lrq_pkg::MODE_XFER_HALF: begin
               if (l_ff == d_ff) begin
                  e_err  = 1'b1;
                  e_code = lrq_pkg::ST_SAME;
               end else if (sc_ff == '0) begin
                  e_err  = 1'b1;
                  e_code = lrq_pkg::ST_EMPTY;
               end
            end
            default: begin
               e_err  = 1'b1;
               e_code = lrq_pkg::ST_MEMBER;
            end
         endcase
      end
   end

   assign stat.clr_last  = (32'(clr_ff) == CLR_MAX - 1);
   assign stat.err       = e_err;
   assign stat.ins       = e_ins;
   assign stat.det       = e_det;
   assign stat.walk_last = (i_ff == k_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // memory port steering
   always_comb begin
      nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
      pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
      tg_we = 1'b0; tg_wa = '0; tg_wd = '0;
      ls_we = 1'b0; ls_wa = LW'(l_ff);
      ls_h  = sh_ff; ls_t = st_ff; ls_c = sc_ff;
      ls_ra = cmd.accept ? LW'(req_list_id) : LW'(d_ff);
      tg_ra = NW'(req_node_in);
      nx_ra = q_sel;
      pv_ra = cmd.tag ? n_ff : q_sel;

      if (cmd.clear) begin
         tg_we = 32'(clr_ff) < NODE_COUNT;
         tg_wa = NW'(clr_ff);
         ls_we = 32'(clr_ff) < LIST_COUNT;
         ls_wa = LW'(clr_ff);
         ls_h  = '0; ls_t = '0; ls_c = '0;
      end

      if (cmd.decide && e_ins) begin
         ls_we = 1'b1;
         ls_c  = sc_ff + CW'(1);
         tg_we = 1'b1;
         tg_wa = p_ff;
         tg_wd = lp1;
         if (sc_ff == '0) begin
            ls_h = p_ff;
            ls_t = p_ff;
         end else if (mode_ff == lrq_pkg::MODE_ENQ_TAIL) begin
            pv_we = 1'b1; pv_wa = p_ff;  pv_wd = st_ff;
            nx_we = 1'b1; nx_wa = st_ff; nx_wd = p_ff;
            ls_t  = p_ff;
         end else begin
            nx_we = 1'b1; nx_wa = p_ff;  nx_wd = sh_ff;
            pv_we = 1'b1; pv_wa = sh_ff; pv_wd = p_ff;
            ls_h  = p_ff;
         end
      end

      if (cmd.link) begin
         ls_we = 1'b1;
         ls_c  = sc_ff - CW'(1);
         tg_we = 1'b1;
         tg_wa = q_ff;
         tg_wd = '0;
         if (sc_ff <= CW'(1)) begin
            ls_h = '0;
            ls_t = '0;
         end else if (st_ff == q_ff) begin
            ls_t = pv_rd;
         end else if (sh_ff == q_ff) begin
            ls_h = nx_rd;
         end else begin
            // middle node: splice neighbors together
            nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
            pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
         end
      end

      if (cmd.tag) begin
         tg_we = 1'b1;
         tg_wa = n_ff;
         tg_wd = dp1;
      end

      if (cmd.xsrc) begin
         ls_we = 1'b1;
         if (k_ff >= sc_ff) begin
            ls_h = '0; ls_t = '0; ls_c = '0;
         end else begin
            ls_t = pn_ff;
            ls_c = sc_ff - k_ff;
         end
         if (dc_ff != '0) begin
            nx_we = 1'b1; nx_wa = dt_ff; nx_wd = n_ff;
            pv_we = 1'b1; pv_wa = n_ff;  pv_wd = dt_ff;
         end
      end

      if (cmd.xdst) begin
         ls_we = 1'b1;
         ls_wa = LW'(d_ff);
         ls_h  = (dc_ff != '0) ? dh_ff : n_ff;
         ls_t  = st_ff;
         ls_c  = dc_ff + k_ff;
      end
   end

   assign ls_wd = {ls_h, ls_t, ls_c};

   lrq_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_next_ram (
      .clock(clock), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
   );
   lrq_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_prev_ram (
      .clock(clock), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
   );
   lrq_ram #(.WIDTH(TW), .DEPTH(NODE_COUNT)) u_tag_ram (
      .clock(clock), .we(tg_we), .waddr(tg_wa), .wdata(tg_wd), .raddr(tg_ra), .rdata(tg_rd)
   );
   lrq_ram #(.WIDTH(DW), .DEPTH(LIST_COUNT)) u_list_ram (
      .clock(clock), .we(ls_we), .waddr(ls_wa), .wdata(ls_wd), .raddr(ls_ra), .rdata(ls_rd)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + CLW'(1);
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         l_ff    <= req_list_id;
         d_ff    <= req_dest_list;
         p_ff    <= NW'(req_node_in);
         p_ok_ff <= 32'(req_node_in) < NODE_COUNT;
      end
      if (cmd.cap_src) begin
         {sh_ff, st_ff, sc_ff} <= ls_rd;
         tag_ff                <= tg_rd;
      end
      if (cmd.cap_dst) begin
         {dh_ff, dt_ff, dc_ff} <= ls_rd;
      end
      if (cmd.decide) begin
         q_ff <= q_sel;
         n_ff <= st_ff;
         k_ff <= k_calc;
         i_ff <= CW'(1);
         res_node_ff   <= e_ins ? lrq_pkg::NODE_W'(p_ff) : '0;
         res_status_ff <= e_code;
         res_moved_ff  <= '0;
         if (e_ins) begin
            res_size_ff <= lrq_pkg::SIZE_W'(sc_ff + CW'(1));
         end else if (l_bad || (mode_ff == lrq_pkg::MODE_XFER_HALF && d_bad)) begin
            res_size_ff <= '0;
         end else begin
            res_size_ff <= lrq_pkg::SIZE_W'(sc_ff);
         end
      end
      if (cmd.link) begin
         res_node_ff <= lrq_pkg::NODE_W'(q_ff);
         res_size_ff <= lrq_pkg::SIZE_W'(sc_ff - CW'(1));
      end
      if (cmd.step) begin
         if (i_ff == k_ff) begin
            pn_ff <= pv_rd;
         end else begin
            n_ff <= pv_rd;
            i_ff <= i_ff + CW'(1);
         end
      end
      if (cmd.xdst) begin
         res_node_ff  <= lrq_pkg::NODE_W'(n_ff);
         res_moved_ff <= lrq_pkg::MOVED_W'(k_ff);
         res_size_ff  <= (k_ff >= sc_ff) ? '0 : lrq_pkg::SIZE_W'(sc_ff - k_ff);
      end
      if (cmd.finish) begin
         rsp_node_ff   <= res_node_ff;
         rsp_status_ff <= res_status_ff;
         rsp_moved_ff  <= res_moved_ff;
         rsp_size_ff   <= res_size_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_out    = rsp_node_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_moved_count = rsp_moved_ff;
   assign rsp_size_after  = rsp_size_ff;
endmodule
`default_nettype wire

// File: hdl/linked_run_queue_manager_unit.sv
// Flow: an accepted word passes the source read, destination read and decide states; inserts
// and errors then finish, removals pass the link state, and a transfer of k nodes runs tag
// and step per node (one prev-link read and one tag write per node), then writes both list
// descriptors. Words are taken one at a time, the link memories having one read port each;
// a result waits while the last response is not yet taken. Reset: a clearing pass zeroes
// membership tags and list descriptors; req_ready stays low until it ends.
`default_nettype none
module linked_run_queue_manager_unit #(
   parameter int NODE_COUNT = lrq_pkg::NODE_COUNT_DEF,
   parameter int LIST_COUNT = lrq_pkg::LIST_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [lrq_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [lrq_pkg::LIST_W-1:0]    req_list_id,
   input  wire logic [lrq_pkg::LIST_W-1:0]    req_dest_list,
   input  wire logic [lrq_pkg::NODE_W-1:0]    req_node_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [lrq_pkg::NODE_W-1:0]    rsp_node_out,
   output logic      [lrq_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [lrq_pkg::MOVED_W-1:0]   rsp_moved_count,
   output logic      [lrq_pkg::SIZE_W-1:0]    rsp_size_after
);
   lrq_pkg::cmd_type  cmd;
   lrq_pkg::stat_type stat;

   lrq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .stat(stat), .cmd(cmd)
   );

   lrq_dpath #(.NODE_COUNT(NODE_COUNT), .LIST_COUNT(LIST_COUNT)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_mode(req_mode), .req_list_id(req_list_id), .req_dest_list(req_dest_list),
      .req_node_in(req_node_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_node_out(rsp_node_out),
      .rsp_status(rsp_status), .rsp_moved_count(rsp_moved_count),
      .rsp_size_after(rsp_size_after)
   );

   a_no_ready_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_ready)
      else $error("word accepted during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while one is in work");

   a_err_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lrq_pkg::ST_OK |-> rsp_node_out == '0 && rsp_moved_count == '0)
      else $error("failed operation reports node or moved count");

   a_moved_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moved_count != '0 |-> rsp_status == lrq_pkg::ST_OK)
      else $error("moved count on failed operation");
endmodule
`default_nettype wire
